// ===== src/efr_pkg.sv =====
// Package with the shared types and constants of the escaped frame receiver.
package efr_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W  = 6;

    localparam logic [7:0] START_ASCII  = 8'h40;
    localparam logic [7:0] START_BINARY = 8'h23;
    localparam logic [7:0] ESCAPE_BYTE  = 8'h5E;
    localparam logic [7:0] END_BYTE     = 8'h0D;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       consumer_busy;
    } t_in;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [POS_W-1:0] position;
        logic             frame_type;
        logic             last;
    } t_out;

    // Write into the frame store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    // Request to read a completed frame out of the store.
    typedef struct packed {
        logic              go;
        logic [ADDR_W-1:0] last_idx;
        logic              ftype;
    } t_rd_cmd;

endpackage

// ===== src/efr_readout.sv =====
// Frame store memory and the read-out sequencer that emits a completed frame.
module efr_readout
    import efr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_wr_req i_wr,
    input  t_rd_cmd i_cmd,
    output logic    o_busy,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_out    o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    t_state            r_state;
    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_last;
    logic              r_type;
    logic              r_out_valid;
    t_out              r_out;
    logic              out_free;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[r_idx];
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.go) begin
                        r_idx   <= '0;
                        r_last  <= i_cmd.last_idx;
                        r_type  <= i_cmd.ftype;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out.out_byte      <= r_rd_data;
                        r_out.position      <= POS_W'(r_idx);
                        r_out.frame_type    <= r_type;
                        r_out.last          <= (r_idx == r_last);
                        if (r_idx == r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The store is never written while a frame is being read out.
    a_no_write_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> (r_state == S_IDLE))
        else $error("frame store written during read-out");

    // A new read-out starts only when the previous one has finished.
    a_cmd_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.go |-> (r_state == S_IDLE))
        else $error("read-out started while busy");

    // The read index never runs past the end of the frame.
    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx <= r_last))
        else $error("read index beyond frame end");

endmodule

// ===== src/escaped_frame_receiver.sv =====
// Top level of the escaped frame receiver: byte decoding and frame assembly.
// Timing: a data byte is stored in the cycle of its transfer; the first result of a
// completed frame passes the S_READ state, then S_LOAD, which holds on a result stall.
// Throughput: one input byte per cycle outside read-out; while a frame is read out
// the input is stalled and each result takes a store read, then the output register.
// Reset clears the write position, escape flag, frame type, sequencer and output valid;
// the frame store is not cleared, since only slots written in the current frame are read.
module escaped_frame_receiver
    import efr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // Decoder state: the write position is zero when no frame is open.
    logic [ADDR_W-1:0] r_wp;
    logic              r_esc;
    logic              r_type;
    logic [ADDR_W-1:0] n_wp;
    logic              n_esc;
    logic              n_type;

    logic    accept;
    logic    frame_open;
    logic    busy;
    t_wr_req wr;
    t_rd_cmd cmd;

    // Input bytes are taken only while the read-out sequencer is idle.
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;
    assign frame_open = (r_wp != '0);

    always_comb begin
        n_wp   = r_wp;
        n_esc  = r_esc;
        n_type = r_type;
        wr     = '0;
        cmd    = '0;
        if (accept) begin
            priority if (i_in_data.rx_byte == START_ASCII ||
                         i_in_data.rx_byte == START_BINARY) begin
                // A start byte always opens a fresh frame at slot zero.
                wr.en   = 1'b1;
                wr.addr = '0;
                wr.data = i_in_data.rx_byte;
                n_wp    = ADDR_W'(1);
                n_type  = (i_in_data.rx_byte == START_BINARY);
                n_esc   = 1'b0;
            end else if (i_in_data.rx_byte == ESCAPE_BYTE) begin
                // The escape byte arms escape even outside a frame.
                n_esc = 1'b1;
            end else if (i_in_data.rx_byte == END_BYTE) begin
                if (frame_open) begin
                    // The end byte is stored as is, then the frame is read out
                    // unless the consumer is busy. Either way the frame closes.
                    wr.en        = 1'b1;
                    wr.addr      = r_wp;
                    wr.data      = END_BYTE;
                    cmd.go       = !i_in_data.consumer_busy;
                    cmd.last_idx = r_wp;
                    cmd.ftype    = r_type;
                    n_wp         = '0;
                    n_esc        = 1'b0;
                end
            end else begin
                if (frame_open) begin
                    // An escaped data byte is stored minus one.
                    wr.en   = 1'b1;
                    wr.addr = r_wp;
                    wr.data = r_esc ? (i_in_data.rx_byte - 8'd1) : i_in_data.rx_byte;
                    n_esc   = 1'b0;
                    // The position saturates so that overlong frames overwrite the
                    // last slot.
                    if (r_wp != ADDR_W'(DEPTH - 1)) begin
                        n_wp = r_wp + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_esc  <= 1'b0;
            r_type <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_esc  <= n_esc;
            r_type <= n_type;
        end
    end

    // The store and sequencer sit behind one boundary; the write port comes
    // from the decoder above and the read-out owns the result channel.
    efr_readout u_readout (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_cmd       (cmd),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/efr_frame_checker.sv =====
// Checker that predicts and compares the result bytes of the escaped frame receiver.
`timescale 1ns / 1ps

module efr_frame_checker
    import efr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    // Shadow copy of the decoder state.
    logic [7:0]        frame_mem [DEPTH];
    logic [POS_W-1:0]  wr_pos;
    logic              esc_armed;
    logic              cur_binary;

    // Frame bytes that the block still owes, oldest first.
    t_out frame_bytes_q [$];
    int   fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    // Applies one received byte to the shadow state and queues any bytes of a
    // completed frame.
    function automatic void decode_rx_byte(input t_in item);
        logic [7:0] b;
        t_out       res;
        b = item.rx_byte;
        if (b == START_ASCII || b == START_BINARY) begin
            frame_mem[0] = b;
            wr_pos       = POS_W'(1);
            cur_binary   = (b == START_BINARY);
            esc_armed    = 1'b0;
        end else if (b == ESCAPE_BYTE) begin
            esc_armed = 1'b1;
        end else if (b == END_BYTE) begin
            if (wr_pos != 0) begin
                frame_mem[wr_pos] = b;
                if (!item.consumer_busy) begin
                    for (int i = 0; i <= int'(wr_pos); i++) begin
                        res.out_byte   = frame_mem[i];
                        res.position   = POS_W'(i);
                        res.frame_type = cur_binary;
                        res.last       = (i == int'(wr_pos));
                        frame_bytes_q.push_back(res);
                    end
                end
                wr_pos    = '0;
                esc_armed = 1'b0;
            end
        end else if (wr_pos != 0) begin
            frame_mem[wr_pos] = esc_armed ? b - 8'd1 : b;
            esc_armed         = 1'b0;
            if (int'(wr_pos) < DEPTH - 1) begin
                wr_pos = wr_pos + 1'b1;
            end
        end
    endfunction

    function automatic void compare_frame_byte(input t_out got);
        t_out want;
        if (frame_bytes_q.size() == 0) begin
            $error("frame byte arrived with nothing expected: byte %02h position %0d",
                   got.out_byte, got.position);
            fail_cnt++;
            return;
        end
        want = frame_bytes_q.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
            fail_cnt++;
        end
        if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            fail_cnt++;
        end
        if (got.frame_type !== want.frame_type) begin
            $error("frame_type: expected %0d, actual %0d", want.frame_type, got.frame_type);
            fail_cnt++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_cnt++;
        end
    endfunction

    // Results are compared before the prediction of the same edge; a result can
    // never belong to a byte that transfers on that very edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_pos     = '0;
            esc_armed  = 1'b0;
            cur_binary = 1'b0;
            frame_bytes_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_frame_byte(i_out_data);
            end
            if (i_in_valid && !i_in_stall) begin
                decode_rx_byte(i_in_data);
            end
        end
        o_pending <= frame_bytes_q.size();
    end

endmodule

// ===== tb/tb_escaped_frame_receiver.sv =====
// Testbench top for the escaped frame receiver: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_escaped_frame_receiver;
    import efr_pkg::*;

    // Generous bound on the run. The slowest correct run is far below it even
    // when every frame byte waits out a long stall on the result side.
    localparam int CYCLE_LIMIT   = 400000;
    // Rough number of random input bytes to send.
    localparam int RANDOM_BYTES  = 320;
    // Cycles allowed after the last expected byte for stray results to show up.
    localparam int DRAIN_CYCLES  = 8;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic in_valid    = 1'b0;
    t_in  in_data     = '0;
    logic out_stall   = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    // When low, neither side idles: the sender offers back to back and the
    // result side never stalls.
    logic idle_on     = 1'b1;
    int unsigned stall_hold = 0;
    int unsigned cycle_cnt  = 0;
    int   bytes_sent  = 0;
    int   fail_count;
    int   pending;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    escaped_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    efr_frame_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Idle lengths: mostly none or a few cycles, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // A payload byte that neither opens nor closes a frame nor arms escape.
    function automatic logic [7:0] pick_body_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == START_ASCII || b == START_BINARY || b == END_BYTE ||
                   b == ESCAPE_BYTE);
        return b;
    endfunction

    // Result-side stall pattern. Each decision holds for a random number of
    // cycles, so stalls land on every phase of a frame read-out.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            out_stall  <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold <= pick_gap();
        end
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offers one byte and returns at the edge where its transfer happens. The
    // valid is only dropped when an idle gap is taken, so back-to-back bytes
    // keep it high without a second assignment in the same step.
    task automatic send_byte(input logic [7:0] b, input logic busy);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid              <= 1'b1;
        in_data.rx_byte       <= b;
        in_data.consumer_busy <= busy;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        bytes_sent++;
    endtask

    // A well-formed frame with random content: start byte, body with some
    // escaped bytes, end byte. Most frames are short; a few run past the
    // store depth so the last slot gets overwritten.
    task automatic send_frame();
        int         body_len;
        logic [7:0] start_b;
        start_b  = $urandom_range(0, 1) ? START_BINARY : START_ASCII;
        body_len = ($urandom_range(0, 19) == 0) ? $urandom_range(DEPTH - 8, DEPTH + 8)
                                                : $urandom_range(0, 10);
        send_byte(start_b, 1'($urandom_range(0, 1)));
        for (int k = 0; k < body_len; k++) begin
            if ($urandom_range(0, 6) == 0) begin
                // Escaped byte; the payload after it may be any value at all,
                // including zero, which wraps to 0xFF when stored.
                send_byte(ESCAPE_BYTE, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0) begin
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else begin
                    send_byte(pick_body_byte(), 1'($urandom_range(0, 1)));
                end
            end else begin
                send_byte(pick_body_byte(), 1'($urandom_range(0, 1)));
            end
        end
        // Occasionally an escape right before the end byte.
        if ($urandom_range(0, 9) == 0) begin
            send_byte(ESCAPE_BYTE, 1'($urandom_range(0, 1)));
        end
        // The consumer is busy on about one end byte in five.
        send_byte(END_BYTE, ($urandom_range(0, 4) == 0));
    endtask

    // Noise: arbitrary bytes, which also produce broken and restarted frames.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Junk and an end byte outside any frame are ignored.
        send_byte(8'h00, 1'b0);
        send_byte(END_BYTE, 1'b0);
        // Escape before a start byte is cleared by the start byte.
        send_byte(ESCAPE_BYTE, 1'b1);
        send_byte(START_ASCII, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Escaped zero wraps to 0xFF.
        send_byte(ESCAPE_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        // Repeated escapes store nothing and stay armed.
        send_byte(ESCAPE_BYTE, 1'b0);
        send_byte(ESCAPE_BYTE, 1'b0);
        send_byte(8'h01, 1'b1);
        // Escape before the end byte leaves the end byte unchanged.
        send_byte(ESCAPE_BYTE, 1'b0);
        send_byte(END_BYTE, 1'b0);
        // A start byte inside a binary frame discards it; the consumer is
        // busy on the end byte, so the restarted frame is dropped.
        send_byte(START_BINARY, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(START_ASCII, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(END_BYTE, 1'b1);
        // Short binary frame that is emitted.
        send_byte(START_BINARY, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(END_BYTE, 1'b0);

        // Random part: mostly well-formed frames, the rest noise. Some frames
        // run with no idling on either side.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            idle_on <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                send_noise();
            end else begin
                send_frame();
            end
        end
        in_valid <= 1'b0;

        // Let the checker see the last transfer, then wait for every owed byte.
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
